// File: rtl/core/ogm_packet_header_timing_top_defines.svh
// Assertion macros for the OGM packet header timing block.
// Used by the top-level RTL file, which carries the assertions; depends on nothing else.
`ifndef OGM_PACKET_HEADER_TIMING_TOP_DEFINES_SVH
`define OGM_PACKET_HEADER_TIMING_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define OGM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define OGM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ogm_pkg.sv
// Shared types and constants for the OGM packet header timing block.
// Used by ogm_conv and the top level; depends on nothing.
`default_nettype none

package ogm_pkg;

    localparam int UNITS_W    = 56;
    localparam int TIME_W     = 64;
    localparam int OUT_TIME_W = 63;
    localparam int CFG_W      = 32;
    localparam int LEN_W      = 3;
    localparam int MUL_STEPS  = 32;
    localparam int DIV_STEPS  = 64;

    localparam logic [1:0] REG_TICK_SCALE   = 2'd0;
    localparam logic [1:0] REG_UNIT_DIVISOR = 2'd1;
    localparam logic [1:0] REG_DEFAULT_LEN  = 2'd2;

    typedef struct packed {
        logic               start;
        logic [UNITS_W-1:0] units;
    } conv_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TIME_W-1:0] quotient;
    } conv_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/ogm_conv.sv
// Unit-to-time converter: units * tick_scale / unit_divisor, wrapping at 64 bits.
// Shift-add multiply, then restoring divide, one bit per cycle; uses ogm_pkg.
`default_nettype none

module ogm_conv (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [ogm_pkg::CFG_W-1:0]   tick_scale,
    input  wire logic [ogm_pkg::CFG_W-1:0]   unit_divisor,
    input  wire ogm_pkg::conv_req_t          req,
    output ogm_pkg::conv_rsp_t               rsp
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_DIV
    } conv_state_t;

    conv_state_t                 state_reg, state_next;
    logic [ogm_pkg::TIME_W-1:0]  mcand_reg, mcand_next;
    logic [ogm_pkg::CFG_W-1:0]   mult_reg, mult_next;
    logic [ogm_pkg::TIME_W-1:0]  acc_reg, acc_next;
    logic [ogm_pkg::CFG_W-1:0]   rem_reg, rem_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [ogm_pkg::CFG_W:0]     rem_sh;
    logic [ogm_pkg::CFG_W:0]     rem_sub;

    assign rem_sh  = {rem_reg, acc_reg[ogm_pkg::TIME_W-1]};
    assign rem_sub = rem_sh - {1'b0, unit_divisor};

    always_comb begin
        state_next = state_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            C_IDLE: begin
                if (req.start) begin
                    mcand_next = ogm_pkg::TIME_W'(req.units);
                    mult_next  = tick_scale;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = C_MUL;
                end
            end
            C_MUL: begin
                if (mult_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[ogm_pkg::TIME_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[ogm_pkg::CFG_W-1:1]};
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ogm_pkg::MUL_STEPS - 1)) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = C_DIV;
                end
            end
            C_DIV: begin
                if (rem_sh >= {1'b0, unit_divisor}) begin
                    rem_next = rem_sub[ogm_pkg::CFG_W-1:0];
                    acc_next = {acc_reg[ogm_pkg::TIME_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[ogm_pkg::CFG_W-1:0];
                    acc_next = {acc_reg[ogm_pkg::TIME_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ogm_pkg::DIV_STEPS - 1)) begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
    end

    assign rsp.busy     = (state_reg != C_IDLE);
    assign rsp.done     = done_reg;
    assign rsp.quotient = acc_reg;

endmodule

`default_nettype wire

// File: rtl/core/ogm_packet_header_timing_top.sv
// Top level of the OGM packet header timing block: byte parser, timing sequencer
// and output register. Depends on ogm_pkg, ogm_conv and the assertion macro header.
//
//   channel | direction | accepted when           | carries
//   s_      | in        | s_tvalid && s_tready    | one packet byte or a new-segment item
//   m_      | out       | m_tvalid && m_tready    | one result per input item
//   cfg_    | in        | cfg_we                  | register write, no read-back
//
// A new-segment item, or a byte that needs no time conversion, puts its result straight into the output register.
// Each time conversion runs on the shared converter (32 multiply steps, 64 divide
// steps, one hand-off) before its result is registered; a first byte with a granule
// that is also the last byte of a timed packet takes two conversions in turn.
// s_tready is low while a conversion is in progress or the result is not taken.
// Reset is synchronous and active low; it clears the running time and parser.
`default_nettype none

`include "ogm_packet_header_timing_top_defines.svh"

module ogm_packet_header_timing_top #(
    parameter int MAX_LENGTH_BYTES = 7
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // data_byte [7:0], granule [55:8], segment_start [118:56], zero [119]
    input  wire logic [119:0] s_tdata,
    // action [0], first_byte [1], granule_valid [2]
    input  wire logic [2:0]   s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // payload_byte [7:0], start_time [70:8], stop_time [133:71],
    // payload_length [165:134], zero [167:166]
    output logic [167:0]      m_tdata,
    // payload_valid [0], header_packet [1], sync_point [2]
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);

    localparam int DUR_W = MAX_LENGTH_BYTES * 8;
    localparam logic [ogm_pkg::LEN_W-1:0] MAX_N = ogm_pkg::LEN_W'(MAX_LENGTH_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GRAN,
        S_STOP
    } top_state_t;

    top_state_t                      state_reg, state_next;
    logic [ogm_pkg::CFG_W-1:0]       tick_scale_reg, tick_scale_next;
    logic [ogm_pkg::CFG_W-1:0]       spu_reg, spu_next;
    logic [ogm_pkg::CFG_W-1:0]       deflen_reg, deflen_next;
    logic [ogm_pkg::TIME_W-1:0]      running_reg, running_next;
    logic [7:0]                      header_reg, header_next;
    logic [ogm_pkg::LEN_W-1:0]       left_reg, left_next;
    logic [ogm_pkg::LEN_W-1:0]       lcount_reg, lcount_next;
    logic [DUR_W-1:0]                dur_reg, dur_next;
    logic [ogm_pkg::CFG_W-1:0]       pcount_reg, pcount_next;
    logic                            need_stop_reg, need_stop_next;
    logic [ogm_pkg::UNITS_W-1:0]     units_reg, units_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_pvalid_reg, out_pvalid_next;
    logic [7:0]                      out_pbyte_reg, out_pbyte_next;
    logic                            out_done_reg, out_done_next;
    logic                            out_hdr_reg, out_hdr_next;
    logic                            out_sync_reg, out_sync_next;
    logic [ogm_pkg::OUT_TIME_W-1:0]  out_start_reg, out_start_next;
    logic [ogm_pkg::OUT_TIME_W-1:0]  out_stop_reg, out_stop_next;
    logic [ogm_pkg::CFG_W-1:0]       out_plen_reg, out_plen_next;

    logic                            in_action;
    logic [7:0]                      in_byte;
    logic                            in_first;
    logic                            in_last;
    logic                            in_gvalid;
    logic [47:0]                     in_granule;
    logic [62:0]                     in_segment;
    logic                            accept;

    logic [7:0]                      p_header;
    logic [ogm_pkg::LEN_W-1:0]       p_left;
    logic [ogm_pkg::LEN_W-1:0]       p_lcount;
    logic [DUR_W-1:0]                p_dur;
    logic [ogm_pkg::CFG_W-1:0]       p_count;
    logic                            p_pvalid;
    logic [7:0]                      p_pbyte;
    logic [ogm_pkg::LEN_W-1:0]       p_pos;
    logic [ogm_pkg::LEN_W-1:0]       p_n;
    logic                            p_need_stop;
    logic [ogm_pkg::UNITS_W-1:0]     p_units;
    logic [ogm_pkg::TIME_W-1:0]      stop_sum;

    ogm_pkg::conv_req_t              conv_req;
    ogm_pkg::conv_rsp_t              conv_rsp;

    assign in_byte    = s_tdata[7:0];
    assign in_granule = s_tdata[55:8];
    assign in_segment = s_tdata[118:56];
    assign in_action  = s_tuser[0];
    assign in_first   = s_tuser[1];
    assign in_gvalid  = s_tuser[2];
    assign in_last    = s_tlast;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Parser update for one packet byte, taken only on a transfer.
    always_comb begin
        p_header = header_reg;
        p_left   = left_reg;
        p_lcount = lcount_reg;
        p_dur    = dur_reg;
        p_count  = pcount_reg;
        p_pvalid = 1'b0;
        p_pbyte  = '0;
        p_pos    = lcount_reg - left_reg;
        p_n      = {in_byte[1], in_byte[7:6]};
        if (in_first) begin
            p_header = in_byte;
            if (in_byte[0]) begin
                p_n = '0;
            end
            if (p_n > MAX_N) begin
                p_n = MAX_N;
            end
            p_lcount = p_n;
            p_left   = p_n;
            p_dur    = '0;
            p_count  = '0;
        end else if (left_reg != '0) begin
            if (p_pos < MAX_N) begin
                p_dur[{p_pos, 3'b000} +: 8] = dur_reg[{p_pos, 3'b000} +: 8] | in_byte;
            end
            p_left = left_reg - ogm_pkg::LEN_W'(1);
        end else if (!header_reg[0]) begin
            p_pvalid = 1'b1;
            p_pbyte  = in_byte;
            p_count  = pcount_reg + 32'd1;
        end
        p_need_stop = in_last && !p_header[0];
        p_units     = (p_lcount != '0) ? ogm_pkg::UNITS_W'(p_dur)
                                       : ogm_pkg::UNITS_W'(deflen_reg);
    end

    assign stop_sum = running_reg + conv_rsp.quotient;

    always_comb begin
        state_next      = state_reg;
        tick_scale_next = tick_scale_reg;
        spu_next        = spu_reg;
        deflen_next     = deflen_reg;
        running_next    = running_reg;
        header_next     = header_reg;
        left_next       = left_reg;
        lcount_next     = lcount_reg;
        dur_next        = dur_reg;
        pcount_next     = pcount_reg;
        need_stop_next  = need_stop_reg;
        units_next      = units_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_pvalid_next = out_pvalid_reg;
        out_pbyte_next  = out_pbyte_reg;
        out_done_next   = out_done_reg;
        out_hdr_next    = out_hdr_reg;
        out_sync_next   = out_sync_reg;
        out_start_next  = out_start_reg;
        out_stop_next   = out_stop_reg;
        out_plen_next   = out_plen_reg;
        conv_req.start  = 1'b0;
        conv_req.units  = p_units;

        if (cfg_we) begin
            unique case (cfg_addr)
                ogm_pkg::REG_TICK_SCALE:   tick_scale_next = cfg_wdata;
                ogm_pkg::REG_UNIT_DIVISOR: spu_next        = cfg_wdata;
                ogm_pkg::REG_DEFAULT_LEN:  deflen_next     = cfg_wdata;
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_start_next = '0;
                    out_stop_next  = '0;
                    if (in_action) begin
                        running_next    = ogm_pkg::TIME_W'(in_segment);
                        out_pvalid_next = 1'b0;
                        out_pbyte_next  = '0;
                        out_done_next   = 1'b0;
                        out_hdr_next    = 1'b0;
                        out_sync_next   = 1'b0;
                        out_plen_next   = '0;
                        out_valid_next  = 1'b1;
                    end else begin
                        header_next     = p_header;
                        lcount_next     = p_lcount;
                        dur_next        = p_dur;
                        left_next       = in_last ? '0 : p_left;
                        pcount_next     = in_last ? '0 : p_count;
                        need_stop_next  = p_need_stop;
                        units_next      = p_units;
                        out_pvalid_next = p_pvalid;
                        out_pbyte_next  = p_pbyte;
                        out_done_next   = in_last;
                        out_hdr_next    = in_last && p_header[0];
                        out_sync_next   = p_need_stop && p_header[3];
                        out_plen_next   = p_need_stop ? p_count : '0;
                        if (in_first && in_gvalid) begin
                            conv_req.start = 1'b1;
                            conv_req.units = ogm_pkg::UNITS_W'(in_granule);
                            state_next     = S_GRAN;
                        end else if (p_need_stop) begin
                            conv_req.start = 1'b1;
                            state_next     = S_STOP;
                        end else begin
                            out_valid_next = 1'b1;
                        end
                    end
                end
            end
            S_GRAN: begin
                if (conv_rsp.done) begin
                    running_next = conv_rsp.quotient;
                    if (need_stop_reg) begin
                        conv_req.start = 1'b1;
                        conv_req.units = units_reg;
                        state_next     = S_STOP;
                    end else begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_STOP: begin
                if (conv_rsp.done) begin
                    out_start_next = running_reg[ogm_pkg::OUT_TIME_W-1:0];
                    out_stop_next  = stop_sum[ogm_pkg::OUT_TIME_W-1:0];
                    running_next   = stop_sum;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tick_scale_reg <= 32'd1;
            spu_reg        <= 32'd1;
            deflen_reg     <= 32'd1;
            running_reg    <= '0;
            header_reg     <= '0;
            left_reg       <= '0;
            lcount_reg     <= '0;
            dur_reg        <= '0;
            pcount_reg     <= '0;
            need_stop_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_scale_reg <= tick_scale_next;
            spu_reg        <= spu_next;
            deflen_reg     <= deflen_next;
            running_reg    <= running_next;
            header_reg     <= header_next;
            left_reg       <= left_next;
            lcount_reg     <= lcount_next;
            dur_reg        <= dur_next;
            pcount_reg     <= pcount_next;
            need_stop_reg  <= need_stop_next;
            out_valid_reg  <= out_valid_next;
        end
        units_reg      <= units_next;
        out_pvalid_reg <= out_pvalid_next;
        out_pbyte_reg  <= out_pbyte_next;
        out_done_reg   <= out_done_next;
        out_hdr_reg    <= out_hdr_next;
        out_sync_reg   <= out_sync_next;
        out_start_reg  <= out_start_next;
        out_stop_reg   <= out_stop_next;
        out_plen_reg   <= out_plen_next;
    end

    ogm_conv u_conv (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_scale   (tick_scale_reg),
        .unit_divisor (spu_reg),
        .req          (conv_req),
        .rsp          (conv_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tuser  = {out_sync_reg, out_hdr_reg, out_pvalid_reg};
    assign m_tdata  = {2'b00, out_plen_reg, out_stop_reg, out_start_reg, out_pbyte_reg};

    `OGM_ASSERT_IMP(a_start_when_idle, conv_req.start, !conv_rsp.busy, "converter started while busy")
    `OGM_ASSERT_IMP(a_done_in_wait, conv_rsp.done, (state_reg == S_GRAN) || (state_reg == S_STOP), "converter result outside a wait state")
    `OGM_ASSERT_IMP(a_left_bounded, 1'b1, left_reg <= lcount_reg, "length bytes left exceed length count")
    `OGM_ASSERT_IMP(a_no_result_while_busy, state_reg != S_IDLE, !m_tvalid, "result shown during a conversion")
    `OGM_ASSERT_NXT(a_granule_loads_time, (state_reg == S_GRAN) && conv_rsp.done, running_reg == $past(conv_rsp.quotient), "granule time not loaded")

endmodule

`default_nettype wire

// File: test/ogm_packet_header_timing_checker.sv
// Transfer monitor and result checker for the OGM packet header timing block.
// Mirrors the register writes, predicts one result per accepted input transfer and
// compares every result transfer against it; depends on ogm_pkg only.
module ogm_packet_header_timing_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic                           payload_valid;
        logic [7:0]                     payload_byte;
        logic                           packet_done;
        logic                           header_packet;
        logic                           sync_point;
        logic [ogm_pkg::OUT_TIME_W-1:0] start_time;
        logic [ogm_pkg::OUT_TIME_W-1:0] stop_time;
        logic [31:0]                    payload_length;
    } pkt_result_t;

    pkt_result_t awaited_results[$];

    logic [ogm_pkg::CFG_W-1:0]   tick_scale;
    logic [ogm_pkg::CFG_W-1:0]   unit_divisor;
    logic [ogm_pkg::CFG_W-1:0]   default_length;

    logic [ogm_pkg::TIME_W-1:0]  running_time;
    logic [7:0]                  header_byte;
    logic [ogm_pkg::LEN_W-1:0]   length_left;
    logic [ogm_pkg::LEN_W-1:0]   length_count;
    logic [ogm_pkg::UNITS_W-1:0] duration;
    logic [31:0]                 payload_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    function automatic logic [ogm_pkg::TIME_W-1:0] to_ticks(
        input logic [ogm_pkg::TIME_W-1:0] units);
        logic [ogm_pkg::TIME_W-1:0] product;
        product = units * {32'd0, tick_scale};
        if (unit_divisor == '0)
            return '1;
        return product / {32'd0, unit_divisor};
    endfunction

    task automatic parse_and_time(input logic new_segment, input logic [7:0] data,
                                  input logic first, input logic last, input logic gvalid,
                                  input logic [47:0] granule,
                                  input logic [ogm_pkg::OUT_TIME_W-1:0] segment_start);
        pkt_result_t                res;
        logic [ogm_pkg::LEN_W-1:0]  pos;
        logic [ogm_pkg::TIME_W-1:0] units;
        logic [ogm_pkg::TIME_W-1:0] stop;
        res = '0;
        if (new_segment) begin
            running_time = {1'b0, segment_start};
        end else begin
            if (first) begin
                if (gvalid)
                    running_time = to_ticks({16'd0, granule});
                header_byte   = data;
                length_count  = data[0] ? 3'd0 : {data[1], data[7:6]};
                length_left   = length_count;
                duration      = '0;
                payload_count = '0;
            end else if (length_left != 0) begin
                pos         = length_count - length_left;
                duration    = duration | ({48'd0, data} << {pos, 3'b000});
                length_left = length_left - 3'd1;
            end else if (!header_byte[0]) begin
                res.payload_valid = 1'b1;
                res.payload_byte  = data;
                payload_count     = payload_count + 32'd1;
            end
            if (last) begin
                res.packet_done   = 1'b1;
                res.header_packet = header_byte[0];
                if (!header_byte[0]) begin
                    units = (length_count != 0) ? {8'd0, duration} : {32'd0, default_length};
                    stop  = running_time + to_ticks(units);
                    res.sync_point     = header_byte[3];
                    res.start_time     = running_time[ogm_pkg::OUT_TIME_W-1:0];
                    res.stop_time      = stop[ogm_pkg::OUT_TIME_W-1:0];
                    res.payload_length = payload_count;
                    running_time       = stop;
                end
                length_left   = '0;
                payload_count = '0;
            end
        end
        awaited_results.push_back(res);
    endtask

    always @(posedge aclk) begin : monitor
        pkt_result_t got;
        pkt_result_t want;
        if (!aresetn) begin
            tick_scale     = 32'd1;
            unit_divisor   = 32'd1;
            default_length = 32'd1;
            running_time   = '0;
            header_byte    = '0;
            length_left    = '0;
            length_count   = '0;
            duration       = '0;
            payload_count  = '0;
            awaited_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    ogm_pkg::REG_TICK_SCALE:   tick_scale     = cfg_wdata;
                    ogm_pkg::REG_UNIT_DIVISOR: unit_divisor   = cfg_wdata;
                    ogm_pkg::REG_DEFAULT_LEN:  default_length = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                parse_and_time(s_tuser[0], s_tdata[7:0], s_tuser[1], s_tlast, s_tuser[2],
                               s_tdata[55:8], s_tdata[118:56]);
            if (m_tvalid && m_tready) begin
                got.payload_valid  = m_tuser[0];
                got.payload_byte   = m_tdata[7:0];
                got.packet_done    = m_tlast;
                got.header_packet  = m_tuser[1];
                got.sync_point     = m_tuser[2];
                got.start_time     = m_tdata[70:8];
                got.stop_time      = m_tdata[133:71];
                got.payload_length = m_tdata[165:134];
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transfer with no result awaited");
                end else begin
                    want = awaited_results.pop_front();
                    check_field("payload_valid", got.payload_valid, want.payload_valid);
                    check_field("payload_byte", got.payload_byte, want.payload_byte);
                    check_field("packet_done", got.packet_done, want.packet_done);
                    check_field("header_packet", got.header_packet, want.header_packet);
                    check_field("sync_point", got.sync_point, want.sync_point);
                    check_field("start_time", got.start_time, want.start_time);
                    check_field("stop_time", got.stop_time, want.stop_time);
                    check_field("payload_length", got.payload_length, want.payload_length);
                end
            end
        end
        pending = awaited_results.size();
    end

endmodule

// File: test/ogm_packet_header_timing_top_tb.sv
// Stimulus and verdict for the OGM packet header timing block: directed packets,
// then random packet streams under several register settings and idle patterns.
// Depends on ogm_pkg, the block's top level and ogm_packet_header_timing_checker.
module ogm_packet_header_timing_top_tb;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 265;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 200;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 4000000;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_addr  = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata   = '0;
    logic [2:0]   s_tuser   = '0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [167:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    int fail_count;
    int pending;
    int items_sent;
    int cycles;
    int phase;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_requested = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    logic [31:0] tu_value;
    logic [31:0] spu_value;
    logic [31:0] dl_value;

    always #10 aclk = ~aclk;

    ogm_packet_header_timing_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    ogm_packet_header_timing_checker checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge aclk) begin
        if (hold_served != hold_requested) begin
            hold_served = hold_requested;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    task automatic push_item(input logic new_segment, input logic [7:0] data,
                             input logic first, input logic last, input logic gvalid,
                             input logic [47:0] granule, input logic [62:0] segment_start);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < tx_idle_pct)
                @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, segment_start, granule, data};
        s_tuser  <= {gvalid, first, new_segment};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic program_regs(input logic [31:0] tu, input logic [31:0] spu,
                                input logic [31:0] dl);
        cfg_we    <= 1'b1;
        cfg_addr  <= ogm_pkg::REG_TICK_SCALE;
        cfg_wdata <= tu;
        @(negedge aclk);
        cfg_addr  <= ogm_pkg::REG_UNIT_DIVISOR;
        cfg_wdata <= spu;
        @(negedge aclk);
        cfg_addr  <= ogm_pkg::REG_DEFAULT_LEN;
        cfg_wdata <= dl;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_packet();
        logic [7:0] hdr;
        logic       gv;
        logic       closed;
        int         kind;
        int         nlen;
        int         nsent;
        int         npay;
        int         total;
        kind = $urandom_range(99);
        if (kind < 5) begin
            push_item(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      rand48(), rand63());
        end else if (kind < 12) begin
            push_item(1'b0, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      rand48(), rand63());
        end else begin
            hdr    = 8'($urandom);
            hdr[0] = ($urandom_range(7) == 0);
            nlen   = hdr[0] ? 0 : int'({hdr[1], hdr[7:6]});
            nsent  = ($urandom_range(9) == 0) ? int'($urandom_range(nlen)) : nlen;
            npay   = ($urandom_range(9) == 0) ? int'($urandom_range(24))
                                              : int'($urandom_range(4));
            closed = ($urandom_range(19) != 0);
            gv     = ($urandom_range(3) == 0);
            total  = 1 + nsent + npay;
            for (int i = 0; i < total; i++)
                push_item(1'b0, (i == 0) ? hdr : 8'($urandom), i == 0,
                          closed && (i == total - 1), (i == 0) ? gv : 1'($urandom),
                          rand48(), rand63());
        end
    endtask

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL ogm_packet_header_timing_top");
        $finish;
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed packets under the reset register values.
        push_item(1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h01, 1'b1, 1'b0, 1'b1, 48'd0, rand63());
        push_item(1'b0, 8'hAA, 1'b0, 1'b0, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h55, 1'b0, 1'b1, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'hCA, 1'b1, 1'b0, 1'b1, '1, rand63());
        repeat (7)
            push_item(1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'hFF, 1'b0, 1'b1, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h80, 1'b1, 1'b0, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h12, 1'b0, 1'b1, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h08, 1'b1, 1'b1, 1'b1, '1, rand63());
        push_item(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h11, 1'b0, 1'b0, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h04, 1'b1, 1'b0, 1'b0, rand48(), rand63());
        push_item(1'b0, 8'h22, 1'b0, 1'b1, 1'b0, rand48(), rand63());
        push_item(1'b1, 8'($urandom), 1'b0, 1'b0, 1'b0, rand48(), '1);
        push_item(1'b0, 8'h33, 1'b0, 1'b1, 1'b0, rand48(), rand63());
        push_item(1'b1, 8'($urandom), 1'b1, 1'b1, 1'b1, rand48(), '0);

        for (phase = 0; phase < PHASES; phase++) begin
            s_tvalid <= 1'b0;
            while (pending != 0)
                @(negedge aclk);
            repeat (SETTLE_CYCLES) @(negedge aclk);
            case (phase)
                0: begin
                    tu_value  = $urandom_range(1000, 1);
                    spu_value = $urandom_range(1000, 1);
                    dl_value  = $urandom;
                end
                1: begin
                    tu_value  = '1;
                    spu_value = 32'd1;
                    dl_value  = '1;
                end
                2: begin
                    tu_value  = $urandom;
                    spu_value = '1;
                    dl_value  = '0;
                end
                3: begin
                    // A zero divisor saturates every conversion.
                    tu_value  = $urandom | 32'd1;
                    spu_value = '0;
                    dl_value  = $urandom;
                end
                4: begin
                    tu_value  = $urandom;
                    spu_value = $urandom | 32'd1;
                    dl_value  = $urandom;
                end
                default: begin
                    tu_value  = 32'd1;
                    spu_value = 32'd1;
                    dl_value  = $urandom_range(255);
                end
            endcase
            program_regs(tu_value, spu_value, dl_value);
            tx_idle_pct  = (phase < 2) ? 7 : (phase < 4) ? 56 : 0;
            rx_idle_pct <= (phase < 2) ? 56 : (phase < 4) ? 7 : 0;
            if (phase == 4)
                hold_requested <= hold_requested + 1;
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                send_random_packet();
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("PASS ogm_packet_header_timing_top");
        else
            $display("FAIL ogm_packet_header_timing_top");
        $finish;
    end

endmodule
